// ===== rtl/brqc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package brqc_pkg;

  localparam int DEPTH  = 256;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // Fixed field widths of the stream beats.
  localparam int CMD_W    = 3;
  localparam int BYTE_W   = 8;
  localparam int OFS_W    = 9;
  localparam int AMT_W    = 9;
  localparam int OCC_W    = 9;
  localparam int STATUS_W = 2;
  localparam int IN_W     = 32;
  localparam int OUT_W    = 24;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH     = 3'd0,
    CMD_POP      = 3'd1,
    CMD_PEEK     = 3'd2,
    CMD_DROP     = 3'd3,
    CMD_CLEAR    = 3'd4,
    CMD_CHECKSUM = 3'd5
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK         = 2'd0,
    STS_POP_EMPTY  = 2'd1,
    STS_PEEK_RANGE = 2'd2,
    STS_OVERWRITE  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SUM
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/brqc_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module brqc_ram #(
  parameter int ADDR_W = 8,
  parameter int DATA_W = 8
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem_r [2**ADDR_W];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== rtl/byte_ring_queue_with_checksum_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Byte ring FIFO, 256 entries, overwriting the oldest byte on a push when full.
// Each input beat is one command and yields exactly one result beat. Push,
// drop, clear, unused codes and the failing cases (pop on empty, peek out of
// range, checksum of zero length) load their result in the cycle they are
// taken, so one such command is taken every cycle while the output register is
// free or being emptied. Pop and peek pass through the read state, as the byte
// store is a single-port-read RAM with a registered read. A checksum walks the
// store one byte per cycle through that read port and sums the data as it
// returns. A new command is taken while the last result still waits in the
// output register, as long as that register is being emptied in the same cycle.
module byte_ring_queue_with_checksum_top (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  // cmd[2:0], data_byte[10:3], offset[19:11], amount[28:20], zero fill above
  input  wire logic [brqc_pkg::IN_W-1:0]    in_tdata,
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  // read_byte[7:0], occupancy[16:8], is_empty[17], is_full[18], status[20:19],
  // zero fill above
  output logic      [brqc_pkg::OUT_W-1:0]   out_tdata
);

  localparam int ADDR_W = brqc_pkg::ADDR_W;
  localparam int CNT_W  = brqc_pkg::CNT_W;
  localparam int BYTE_W = brqc_pkg::BYTE_W;

  brqc_pkg::state_t state_r, state_nxt;

  logic [ADDR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [ADDR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  fill_r, fill_nxt;

  // Checksum walk.
  logic [ADDR_W-1:0] sum_addr_r, sum_addr_nxt;
  logic [CNT_W-1:0]  remain_r, remain_nxt;
  logic [BYTE_W-1:0] sum_r, sum_nxt;

  // Output register.
  logic                        out_valid_r;
  logic [BYTE_W-1:0]           out_byte_r, out_byte_nxt;
  logic [CNT_W-1:0]            out_occ_r, out_occ_nxt;
  brqc_pkg::status_t           out_status_r, out_status_nxt;
  logic                        out_load;

  // RAM ports.
  logic              ram_wr_en;
  logic [ADDR_W-1:0] ram_wr_addr;
  logic [BYTE_W-1:0] ram_wr_data;
  logic              ram_rd_en;
  logic [ADDR_W-1:0] ram_rd_addr;
  logic [BYTE_W-1:0] ram_rd_data;

  // Input fields.
  brqc_pkg::cmd_t              in_cmd;
  logic [BYTE_W-1:0]           in_byte;
  logic [brqc_pkg::OFS_W-1:0]  in_offset;
  logic [brqc_pkg::AMT_W-1:0]  in_amount;
  logic                        in_fire;

  logic [CNT_W-1:0]  ofs_cnt;
  logic [CNT_W-1:0]  amt_cnt;
  logic [CNT_W-1:0]  avail;
  logic [CNT_W-1:0]  sum_len;
  logic [CNT_W-1:0]  drop_len;
  logic              is_full_now;

  assign in_cmd    = brqc_pkg::cmd_t'(in_tdata[2:0]);
  assign in_byte   = in_tdata[10:3];
  assign in_offset = in_tdata[19:11];
  assign in_amount = in_tdata[28:20];

  assign in_tready = (state_r == brqc_pkg::S_IDLE) && (!out_valid_r || out_tready);
  assign in_fire   = in_tvalid && in_tready;

  assign is_full_now = (fill_r == CNT_W'(brqc_pkg::DEPTH));

  // Offset and amount are clipped to the fill level.
  assign ofs_cnt  = (in_offset >= fill_r) ? fill_r : CNT_W'(in_offset);
  assign amt_cnt  = (in_amount >= fill_r) ? fill_r : CNT_W'(in_amount);
  assign avail    = fill_r - ofs_cnt;
  assign sum_len  = (amt_cnt < avail) ? amt_cnt : avail;
  assign drop_len = amt_cnt;

  brqc_ram #(
    .ADDR_W (ADDR_W),
    .DATA_W (BYTE_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  always_comb begin
    state_nxt      = state_r;
    wr_ptr_nxt     = wr_ptr_r;
    rd_ptr_nxt     = rd_ptr_r;
    fill_nxt       = fill_r;
    sum_addr_nxt   = sum_addr_r;
    remain_nxt     = remain_r;
    sum_nxt        = sum_r;
    out_load       = 1'b0;
    out_byte_nxt   = '0;
    out_occ_nxt    = fill_r;
    out_status_nxt = brqc_pkg::STS_OK;
    ram_wr_en      = 1'b0;
    ram_wr_addr    = wr_ptr_r;
    ram_wr_data    = in_byte;
    ram_rd_en      = 1'b0;
    ram_rd_addr    = rd_ptr_r;

    unique case (state_r)
      brqc_pkg::S_IDLE: begin
        if (in_fire) begin
          out_load = 1'b1;
          case (in_cmd)
            brqc_pkg::CMD_PUSH: begin
              ram_wr_en  = 1'b1;
              wr_ptr_nxt = wr_ptr_r + ADDR_W'(1);
              if (is_full_now) begin
                rd_ptr_nxt     = rd_ptr_r + ADDR_W'(1);
                out_status_nxt = brqc_pkg::STS_OVERWRITE;
              end else begin
                fill_nxt = fill_r + CNT_W'(1);
              end
            end
            brqc_pkg::CMD_POP: begin
              if (fill_r == '0) begin
                out_status_nxt = brqc_pkg::STS_POP_EMPTY;
              end else begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = rd_ptr_r;
                rd_ptr_nxt  = rd_ptr_r + ADDR_W'(1);
                fill_nxt    = fill_r - CNT_W'(1);
                out_load    = 1'b0;
                state_nxt   = brqc_pkg::S_READ;
              end
            end
            brqc_pkg::CMD_PEEK: begin
              if (in_offset >= fill_r) begin
                out_status_nxt = brqc_pkg::STS_PEEK_RANGE;
              end else begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = rd_ptr_r + ADDR_W'(ofs_cnt);
                out_load    = 1'b0;
                state_nxt   = brqc_pkg::S_READ;
              end
            end
            brqc_pkg::CMD_DROP: begin
              rd_ptr_nxt = rd_ptr_r + ADDR_W'(drop_len);
              fill_nxt   = fill_r - drop_len;
            end
            brqc_pkg::CMD_CLEAR: begin
              wr_ptr_nxt = '0;
              rd_ptr_nxt = '0;
              fill_nxt   = '0;
            end
            brqc_pkg::CMD_CHECKSUM: begin
              if (sum_len != '0) begin
                ram_rd_en    = 1'b1;
                ram_rd_addr  = rd_ptr_r + ADDR_W'(ofs_cnt);
                sum_addr_nxt = rd_ptr_r + ADDR_W'(ofs_cnt) + ADDR_W'(1);
                remain_nxt   = sum_len - CNT_W'(1);
                sum_nxt      = '0;
                out_load     = 1'b0;
                state_nxt    = brqc_pkg::S_SUM;
              end
            end
            default: begin
            end
          endcase
          out_occ_nxt = fill_nxt;
        end
      end
      brqc_pkg::S_READ: begin
        out_load     = 1'b1;
        out_byte_nxt = ram_rd_data;
        state_nxt    = brqc_pkg::S_IDLE;
      end
      brqc_pkg::S_SUM: begin
        // Each cycle here has one byte returning from the read issued the cycle before.
        sum_nxt = sum_r + ram_rd_data;
        if (remain_r != '0) begin
          ram_rd_en    = 1'b1;
          ram_rd_addr  = sum_addr_r;
          sum_addr_nxt = sum_addr_r + ADDR_W'(1);
          remain_nxt   = remain_r - CNT_W'(1);
        end else begin
          out_load     = 1'b1;
          out_byte_nxt = sum_nxt;
          state_nxt    = brqc_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = brqc_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= brqc_pkg::S_IDLE;
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    sum_addr_r <= sum_addr_nxt;
    remain_r   <= remain_nxt;
    sum_r      <= sum_nxt;
    if (out_load) begin
      out_byte_r   <= out_byte_nxt;
      out_occ_r    <= out_occ_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {
    3'b000,
    out_status_r,
    (out_occ_r == CNT_W'(brqc_pkg::DEPTH)),
    (out_occ_r == '0),
    brqc_pkg::OCC_W'(out_occ_r),
    out_byte_r
  };

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(brqc_pkg::DEPTH))
    else $error("fill count above depth");

  a_ptr_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_ptr_r + ADDR_W'(fill_r)) == wr_ptr_r)
    else $error("pointers disagree with fill count");

  a_sum_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == brqc_pkg::S_SUM) && (remain_r == '0) |=> out_valid_r &&
      (state_r == brqc_pkg::S_IDLE))
    else $error("checksum finished without a result");

  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == brqc_pkg::S_READ) |=> out_valid_r)
    else $error("pop or peek finished without a result");

endmodule

`default_nettype wire
